// ----- rtl/core/ksds_pkg.sv -----
// shared types and constants of the k smallest distance selector
package ksds_pkg;

    localparam int DIST_W        = 32;
    localparam int POS_W         = 12;
    localparam int FLOOR_W       = 16;
    localparam int RANK_W        = 4;
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 16'd1;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] distance;
        logic [POS_W-1:0]  pos;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic drain;
    } t_ctrl;

endpackage

// ----- rtl/core/k_smallest_distance_selector_core.sv -----
// top level of the k smallest distance selector: cell chain, counter and result drain
//
// Input channel: one candidate distance (unsigned Q16.16) per word with a
// last flag; a word moves when i_in_valid is high and o_in_stall is low.
// Every candidate is raised to the floor register and inserted into a row of
// KEEP cells in the cycle it is accepted, so candidates go in one per cycle
// while o_in_stall is low. Output channel: after a word flagged last, the
// chain shifts out through cell 0 and gives KEEP ranked result words, one
// per cycle while i_out_stall is low; each result goes from cell 0 into the
// output register. o_in_stall stays high for those KEEP drain steps.
// Draining leaves the chain empty, ready for the next set. A stalled
// receiver holds the output register and pauses the drain. Configuration:
// i_cfg_data is written when i_cfg_valid is high (o_cfg_ready is always
// high); write it only while the block is idle. Reset empties all slots,
// zeroes the position counter and the overflow flag and sets the floor to 1.
module k_smallest_distance_selector_core
    import ksds_pkg::*;
#(
    parameter int KEEP           = 5,
    parameter int MAX_CANDIDATES = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [FLOOR_W-1:0]  i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [DIST_W-1:0]   i_candidate_distance,
    input  logic                i_last_candidate,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [RANK_W-1:0]   o_rank,
    output logic [POS_W-1:0]    o_best_position,
    output logic [DIST_W-1:0]   o_best_distance_out,
    output logic                o_slot_valid,
    output logic                o_count_overflow,
    output logic                o_last_result
);

    localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
    localparam int EXT_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CANDIDATES);
    localparam logic [RANK_W-1:0] RANK_LAST = RANK_W'(KEEP - 1);

    logic [FLOOR_W-1:0] r_floor;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_ovf;
    logic               r_drain;
    logic               r_drain_ovf;
    logic [RANK_W-1:0]  r_rank;

    logic               r_out_valid;
    logic [RANK_W-1:0]  r_out_rank;
    logic [POS_W-1:0]   r_out_pos;
    logic [DIST_W-1:0]  r_out_dist;
    logic               r_out_slot;
    logic               r_out_ovf;
    logic               r_out_last;

    logic               w_in_acc;
    logic               w_step;
    logic               w_sat;
    logic [DIST_W-1:0]  w_floor_ext;
    logic [CNT_W-1:0]   w_pos_cnt;
    logic [EXT_W-1:0]   w_pos_ext;
    t_entry             w_cand;
    t_ctrl              w_ctrl;
    t_entry             w_entry [KEEP];
    logic               w_pred  [KEEP];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_drain;
    assign w_in_acc    = i_in_valid && !r_drain;
    // a drain step moves one word into the output register
    assign w_step      = r_drain && (!r_out_valid || !i_out_stall);

    assign w_floor_ext = DIST_W'(r_floor);
    assign w_sat       = (r_cnt == CNT_MAX);
    assign w_pos_cnt   = w_sat ? (CNT_MAX - 1'b1) : r_cnt;
    assign w_pos_ext   = EXT_W'(w_pos_cnt);

    always_comb begin
        w_cand.valid    = 1'b1;
        w_cand.distance = (i_candidate_distance < w_floor_ext) ? w_floor_ext
                                                               : i_candidate_distance;
        w_cand.pos      = w_pos_ext[POS_W-1:0];
    end

    assign w_ctrl.insert = w_in_acc;
    assign w_ctrl.drain  = w_step;

    for (genvar g = 0; g < KEEP; g++) begin : g_cell
        t_entry w_lo;
        t_entry w_hi;
        logic   w_plo;
        if (g == 0) begin : g_first
            assign w_lo  = w_cand;
            assign w_plo = 1'b0;
        end else begin : g_mid
            assign w_lo  = w_entry[g-1];
            assign w_plo = w_pred[g-1];
        end
        if (g == KEEP - 1) begin : g_end
            assign w_hi = '0;
        end else begin : g_inner
            assign w_hi = w_entry[g+1];
        end
        ksds_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_cand    (w_cand),
            .i_from_lo (w_lo),
            .i_pred_lo (w_plo),
            .i_from_hi (w_hi),
            .o_entry   (w_entry[g]),
            .o_pred    (w_pred[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor     <= FLOOR_RESET;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_drain     <= 1'b0;
            r_drain_ovf <= 1'b0;
            r_rank      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_floor <= i_cfg_data;
            end
            if (w_in_acc) begin
                if (i_last_candidate) begin
                    r_cnt       <= '0;
                    r_ovf       <= 1'b0;
                    r_drain     <= 1'b1;
                    r_drain_ovf <= r_ovf || w_sat;
                    r_rank      <= '0;
                end else begin
                    if (w_sat) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
                r_rank      <= r_rank + 1'b1;
                if (r_rank == RANK_LAST) begin
                    r_drain <= 1'b0;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_rank <= r_rank;
            r_out_slot <= w_entry[0].valid;
            r_out_pos  <= w_entry[0].valid ? w_entry[0].pos : '0;
            r_out_dist <= w_entry[0].valid ? w_entry[0].distance : '0;
            r_out_ovf  <= r_drain_ovf;
            r_out_last <= (r_rank == RANK_LAST);
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_rank              = r_out_rank;
    assign o_best_position     = r_out_pos;
    assign o_best_distance_out = r_out_dist;
    assign o_slot_valid        = r_out_slot;
    assign o_count_overflow    = r_out_ovf;
    assign o_last_result       = r_out_last;

endmodule

// ----- rtl/core/ksds_cell.sv -----
// one slot of the sorted chain: compare, take the candidate or a neighbour's entry, or keep
module ksds_cell
    import ksds_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_ctrl  i_ctrl,
    input  t_entry i_cand,
    input  t_entry i_from_lo,
    input  logic   i_pred_lo,
    input  t_entry i_from_hi,
    output t_entry o_entry,
    output logic   o_pred
);

    logic   r_valid;
    logic [DIST_W-1:0] r_dist;
    logic [POS_W-1:0]  r_pos;
    t_entry n_entry;

    // the candidate belongs at or before this slot
    assign o_pred = !r_valid || (i_cand.distance < r_dist);

    always_comb begin
        n_entry = '{valid: r_valid, distance: r_dist, pos: r_pos};
        if (i_ctrl.drain) begin
            n_entry = i_from_hi;
        end else if (i_ctrl.insert) begin
            if (i_pred_lo) begin
                n_entry = i_from_lo;
            end else if (o_pred) begin
                n_entry = i_cand;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist <= n_entry.distance;
        r_pos  <= n_entry.pos;
    end

    assign o_entry = '{valid: r_valid, distance: r_dist, pos: r_pos};

endmodule
